>>> src/qles_pkg.sv
`timescale 1ns / 1ps
package qles_pkg;

	localparam int CP_W = 21;
	localparam int QUOTE_W = 7;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OPEN    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CONT    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_END     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADESC  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NEWLINE = 3'd5;

	localparam logic [QUOTE_W-1:0] QUOTE_RESET = 7'd34;
	localparam logic [1:0] OCTAL_MAX = 2'd3;

	localparam logic [CP_W-1:0] CH_NEWLINE   = 21'd10;
	localparam logic [CP_W-1:0] CH_DQUOTE    = 21'd34;
	localparam logic [CP_W-1:0] CH_SQUOTE    = 21'd39;
	localparam logic [CP_W-1:0] CH_QMARK     = 21'd63;
	localparam logic [CP_W-1:0] CH_BACKSLASH = 21'd92;
	localparam logic [CP_W-1:0] CH_0         = 21'd48;
	localparam logic [CP_W-1:0] CH_7         = 21'd55;
	localparam logic [CP_W-1:0] CH_9         = 21'd57;
	localparam logic [CP_W-1:0] CH_UA        = 21'd65;
	localparam logic [CP_W-1:0] CH_UF        = 21'd70;
	localparam logic [CP_W-1:0] CH_LA        = 21'd97;
	localparam logic [CP_W-1:0] CH_LB        = 21'd98;
	localparam logic [CP_W-1:0] CH_LF        = 21'd102;
	localparam logic [CP_W-1:0] CH_LN        = 21'd110;
	localparam logic [CP_W-1:0] CH_LR        = 21'd114;
	localparam logic [CP_W-1:0] CH_LT        = 21'd116;
	localparam logic [CP_W-1:0] CH_LV        = 21'd118;
	localparam logic [CP_W-1:0] CH_LX        = 21'd120;

	localparam logic [0:0] REG_QUOTE = 1'b0;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_oct;
		logic            is_hex;
		logic            is_x;
		logic            is_simple;
		logic            is_bs;
		logic            is_nl;
		logic            is_quote;
	} cls_t;

endpackage

>>> src/qles_if.sv
`timescale 1ns / 1ps
interface qles_in_if;
	logic                        valid;
	logic                        ready;
	logic [qles_pkg::CP_W-1:0]   code_point;

	modport source (output valid, output code_point, input ready);
	modport sink (input valid, input code_point, output ready);
endinterface

interface qles_out_if;
	logic                          valid;
	logic                          ready;
	logic [qles_pkg::STATUS_W-1:0] status;
	logic [qles_pkg::CP_W-1:0]     echo_point;

	modport source (output valid, output status, output echo_point, input ready);
	modport sink (input valid, input status, input echo_point, output ready);
endinterface

>>> src/quoted_literal_escape_scanner.sv
`timescale 1ns / 1ps
// channel   dir  beat payload                       handshake
// in_item   in   code_point[20:0]                   valid/ready
// out_item  out  status[2:0], echo_point[20:0]      valid/ready
// apb       in   quote_char at 0x0 (7 bits)         psel/penable, pready=1
//
// One beat per cycle while out_item is ready; each beat is queued, then registered.
// The front classifies each beat and pushes it into a QUEUE_DEPTH-entry queue;
// the back updates the literal state on each pop and registers the result.
// in_item.ready drops only when the queue is full; out_item stalls hold the
// back while the front keeps filling the queue.
// Reset clears literal state, queue and output valid; quote_char returns to 34.
module quoted_literal_escape_scanner #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	qles_in_if.sink       in_item,
	qles_out_if.source    out_item,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic [qles_pkg::QUOTE_W-1:0] quote_q;
	logic                         full;
	logic                         push;
	qles_pkg::cls_t               push_data;
	logic                         pop;
	logic                         not_empty;
	qles_pkg::cls_t               pop_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == qles_pkg::REG_QUOTE) ?
		{{(32 - qles_pkg::QUOTE_W){1'b0}}, quote_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= qles_pkg::QUOTE_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == qles_pkg::REG_QUOTE)) begin
			quote_q <= pwdata[qles_pkg::QUOTE_W-1:0];
		end
	end

	qles_front u_front (
		.in_item   (in_item),
		.quote     (quote_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	qles_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.pop_data  (pop_data)
	);

	qles_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.item      (pop_data),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

>>> src/qles_front.sv
`timescale 1ns / 1ps
module qles_front (
	qles_in_if.sink                         in_item,
	input  logic [qles_pkg::QUOTE_W-1:0]    quote,
	input  logic                            full,
	output logic                            push,
	output qles_pkg::cls_t                  push_data
);

	logic [qles_pkg::CP_W-1:0] c;

	assign c = in_item.code_point;
	assign in_item.ready = !full;
	assign push = in_item.valid && !full;

	always_comb begin
		push_data.code_point = c;
		push_data.is_oct = (c >= qles_pkg::CH_0) && (c <= qles_pkg::CH_7);
		push_data.is_hex = ((c >= qles_pkg::CH_0) && (c <= qles_pkg::CH_9)) ||
			((c >= qles_pkg::CH_LA) && (c <= qles_pkg::CH_LF)) ||
			((c >= qles_pkg::CH_UA) && (c <= qles_pkg::CH_UF));
		push_data.is_x = (c == qles_pkg::CH_LX);
		push_data.is_simple = (c == qles_pkg::CH_SQUOTE) || (c == qles_pkg::CH_DQUOTE) ||
			(c == qles_pkg::CH_QMARK) || (c == qles_pkg::CH_BACKSLASH) ||
			(c == qles_pkg::CH_LA) || (c == qles_pkg::CH_LB) ||
			(c == qles_pkg::CH_LF) || (c == qles_pkg::CH_LN) ||
			(c == qles_pkg::CH_LR) || (c == qles_pkg::CH_LT) ||
			(c == qles_pkg::CH_LV);
		push_data.is_bs = (c == qles_pkg::CH_BACKSLASH);
		push_data.is_nl = (c == qles_pkg::CH_NEWLINE);
		push_data.is_quote = (c == {{(qles_pkg::CP_W - qles_pkg::QUOTE_W){1'b0}}, quote});
	end

endmodule

>>> src/qles_queue.sv
`timescale 1ns / 1ps
module qles_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qles_pkg::cls_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output qles_pkg::cls_t  pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qles_pkg::cls_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

>>> src/qles_back.sv
`timescale 1ns / 1ps
module qles_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  qles_pkg::cls_t  item,
	output logic            pop,
	qles_out_if.source      out_item
);

	logic                            in_lit_q;
	logic                            bs_odd_q;
	logic [1:0]                      oct_cnt_q;
	logic                            hex_q;
	logic                            out_vld_q;
	logic [qles_pkg::STATUS_W-1:0]   status_q;
	logic [qles_pkg::CP_W-1:0]       echo_q;

	logic                            in_lit_d;
	logic                            bs_odd_d;
	logic [1:0]                      oct_cnt_d;
	logic                            hex_d;
	logic [qles_pkg::STATUS_W-1:0]   st;

	assign pop = not_empty && (!out_vld_q || out_item.ready);
	assign out_item.valid = out_vld_q;
	assign out_item.status = status_q;
	assign out_item.echo_point = echo_q;

	always_comb begin
		in_lit_d = in_lit_q;
		bs_odd_d = bs_odd_q;
		oct_cnt_d = oct_cnt_q;
		hex_d = hex_q;
		st = qles_pkg::ST_CONT;
		if (!in_lit_q) begin
			if (item.is_quote) begin
				in_lit_d = 1'b1;
				bs_odd_d = item.is_bs;
				oct_cnt_d = 2'd0;
				hex_d = 1'b0;
				st = qles_pkg::ST_OPEN;
			end else begin
				st = qles_pkg::ST_REJECT;
			end
		end else begin
			if ((oct_cnt_q != 2'd0) && (oct_cnt_q < qles_pkg::OCTAL_MAX) && item.is_oct) begin
				oct_cnt_d = oct_cnt_q + 2'd1;
			end else if (hex_q && item.is_hex) begin
				hex_d = 1'b1;
			end else if (bs_odd_q) begin
				if (item.is_oct) begin
					oct_cnt_d = 2'd1;
				end else if (item.is_x) begin
					hex_d = 1'b1;
				end else if (!item.is_simple) begin
					st = qles_pkg::ST_BADESC;
				end
			end else begin
				oct_cnt_d = 2'd0;
				hex_d = 1'b0;
				if (item.is_nl) begin
					st = qles_pkg::ST_NEWLINE;
				end else if (item.is_quote) begin
					st = qles_pkg::ST_END;
				end
			end
			if (st == qles_pkg::ST_CONT) begin
				bs_odd_d = item.is_bs ? !bs_odd_q : 1'b0;
			end else begin
				in_lit_d = 1'b0;
				bs_odd_d = 1'b0;
				oct_cnt_d = 2'd0;
				hex_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_lit_q <= 1'b0;
			bs_odd_q <= 1'b0;
			oct_cnt_q <= 2'd0;
			hex_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				in_lit_q <= in_lit_d;
				bs_odd_q <= bs_odd_d;
				oct_cnt_q <= oct_cnt_d;
				hex_q <= hex_d;
				out_vld_q <= 1'b1;
			end else if (out_item.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= st;
			echo_q <= ((st == qles_pkg::ST_OPEN) || (st == qles_pkg::ST_CONT) ||
				(st == qles_pkg::ST_END)) ? item.code_point : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_err_echo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && ((status_q == qles_pkg::ST_REJECT) || (status_q == qles_pkg::ST_BADESC) ||
		(status_q == qles_pkg::ST_NEWLINE)) |-> (echo_q == '0))
		else $error("echo not cleared on reject or error");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_lit_q |-> (!bs_odd_q && (oct_cnt_q == 2'd0) && !hex_q))
		else $error("escape state left over while idle");
	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && in_lit_q && (st != qles_pkg::ST_CONT) |=> !in_lit_q)
		else $error("literal still open after end or error");
	a_open_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (st == qles_pkg::ST_OPEN) |-> !in_lit_q)
		else $error("open reported inside a literal");
`endif

endmodule
